// ----- rtl/linear_probe_hash_table_macros.svh -----
// assertion macros for the hash table rtl
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// condition that must hold at every clock edge out of reset
`define LPHT_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// same-cycle implication
`define LPHT_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lpht_pkg.sv -----
package lpht_pkg;

	localparam int CMD_W    = 2;
	localparam int KEY_W    = 64;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_PUT    = 2'd0;
	localparam logic [CMD_W-1:0] CMD_GET    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [KEY_W-1:0]    key_t;
	typedef logic [VALUE_W-1:0]  value_t;
	typedef logic [STATUS_W-1:0] status_t;

endpackage

// ----- rtl/lpht_if.sv -----
interface lpht_in_if;
	logic              valid;
	logic              ready;
	lpht_pkg::cmd_t    command;
	lpht_pkg::key_t    key;
	lpht_pkg::value_t  value;

	modport source (output valid, command, key, value, input ready);
	modport sink (input valid, command, key, value, output ready);
endinterface

interface lpht_out_if;
	logic              valid;
	logic              ready;
	lpht_pkg::status_t status;
	lpht_pkg::value_t  value_out;

	modport source (output valid, status, value_out, input ready);
	modport sink (input valid, status, value_out, output ready);
endinterface

// ----- rtl/lpht_hash.sv -----
module lpht_hash #(
	parameter int CAPACITY  = 16,
	parameter int KEY_BYTES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [8*KEY_BYTES-1:0]        key,
	output logic                          done,
	output logic [$clog2(CAPACITY)-1:0]   home
);

	localparam int ADDR_W  = $clog2(CAPACITY);
	localparam int SUM_W   = $clog2(KEY_BYTES * 255 + 1);
	localparam int SHIFT   = SUM_W + ADDR_W;
	localparam int RECIP_W = SUM_W + 2;
	localparam int PROD_W  = SUM_W + RECIP_W;
	localparam int QC_W    = SUM_W + ADDR_W + 1;
	localparam longint unsigned RECIP =
		((64'd1 << SHIFT) + 64'(CAPACITY) - 64'd1) / 64'(CAPACITY);

	logic [SUM_W-1:0]  byte_sum;
	logic [PROD_W-1:0] recip_prod;
	logic [QC_W-1:0]   quot_prod;
	logic [SUM_W-1:0]  rem;
	logic              vld_s1;
	logic              vld_s2;
	logic [SUM_W-1:0]  sum_s1;
	logic [SUM_W-1:0]  sum_s2;
	logic [SUM_W-1:0]  quot_s2;
	logic [ADDR_W-1:0] home_q;
	logic              done_q;

	always_comb begin
		byte_sum = '0;
		for (int b = 0; b < KEY_BYTES; b++) begin
			byte_sum = byte_sum + SUM_W'(key[8*b +: 8]);
		end
	end

	// quotient by the rounded-up reciprocal of the capacity, exact for every byte sum
	assign recip_prod = PROD_W'(sum_s1) * PROD_W'(RECIP);
	assign quot_prod  = QC_W'(quot_s2) * QC_W'(CAPACITY);
	assign rem        = sum_s2 - quot_prod[SUM_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			done_q  <= 1'b0;
			sum_s1  <= '0;
			sum_s2  <= '0;
			quot_s2 <= '0;
			home_q  <= '0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
			if (start) begin
				sum_s1 <= byte_sum;
			end
			if (vld_s1) begin
				sum_s2  <= sum_s1;
				quot_s2 <= SUM_W'(recip_prod >> SHIFT);
			end
			if (vld_s2) begin
				home_q <= ADDR_W'(rem);
			end
		end
	end

	assign done = done_q;
	assign home = home_q;

endmodule

// ----- rtl/lpht_mem.sv -----
module lpht_mem #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 97
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ----- rtl/linear_probe_hash_table.sv -----
// Hash table of CAPACITY key/value slots with linear probing, one command at a time.
// A command is taken while in_ch.ready is high. Put, get and get-and-remove first form
// the home slot in registered steps (byte sum of the key, quotient by the
// capacity through a reciprocal multiplication, remainder), then walk the slot memory
// from home one slot per cycle through its single read port, each slot checked the
// cycle after its read. The walk ends at the first slot that decides the command, or
// once it has covered every slot, as a miss does; the result then moves to the output
// register, and in_ch.ready returns as it does so. A put on a full table skips the
// walk and answers once the home slot is formed. A clear sweeps the memory one slot
// per cycle and then answers; the same sweep runs after reset before the first command
// is taken. A finished result waits in the output register while the next command is
// taken, and a newer result holds the table until that register is free.
`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table #(
	parameter int CAPACITY   = 16,
	parameter int KEY_BYTES  = 8,
	parameter int VALUE_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	lpht_in_if.sink     in_ch,
	lpht_out_if.source  out_ch
);

	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int KEY_BITS = 8 * KEY_BYTES;
	localparam int MW       = 1 + KEY_BITS + VALUE_BITS;
	localparam int VW       = (VALUE_BITS > lpht_pkg::VALUE_W) ? VALUE_BITS : lpht_pkg::VALUE_W;

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_HASH   = 3'd2;
	localparam logic [2:0] ST_PROBE  = 3'd3;
	localparam logic [2:0] ST_CLEAR  = 3'd4;
	localparam logic [2:0] ST_RESULT = 3'd5;

	logic [2:0]              state_q;
	logic [ADDR_W-1:0]       addr_q;
	logic [ADDR_W-1:0]       addr_next;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        issued_q;
	lpht_pkg::cmd_t          cmd_q;
	logic [KEY_BITS-1:0]     key_q;
	logic [VALUE_BITS-1:0]   val_q;
	lpht_pkg::status_t       res_status_q;
	lpht_pkg::value_t        res_value_q;
	logic                    out_valid_q;
	lpht_pkg::status_t       out_status_q;
	lpht_pkg::value_t        out_value_q;

	logic                    rd_vld_s1;
	logic                    rd_last_s1;
	logic [ADDR_W-1:0]       rd_addr_s1;

	logic                    in_accept;
	logic                    hash_start;
	logic                    hash_done;
	logic [ADDR_W-1:0]       hash_home;

	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_waddr;
	logic [MW-1:0]           mem_wdata;
	logic [MW-1:0]           mem_rdata;

	logic                    rd_used;
	logic [KEY_BITS-1:0]     rd_key;
	logic [VALUE_BITS-1:0]   rd_val;
	logic [VW-1:0]           in_val_ext;
	logic [VW-1:0]           rd_val_ext;
	logic                    issue;
	logic                    slot_match;
	logic                    probe_hit;
	logic                    probe_miss_end;
	logic                    put_hit;
	logic                    mem_sweep;
	logic                    out_load;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign in_accept   = in_ch.valid && in_ch.ready;
	assign hash_start  = in_accept && (in_ch.command != lpht_pkg::CMD_CLEAR);

	assign addr_next = (addr_q == ADDR_W'(CAPACITY - 1)) ? '0 : addr_q + 1'b1;

	assign rd_used    = mem_rdata[MW-1];
	assign rd_key     = mem_rdata[MW-2 -: KEY_BITS];
	assign rd_val     = mem_rdata[VALUE_BITS-1:0];
	assign in_val_ext = VW'(in_ch.value);
	assign rd_val_ext = VW'(rd_val);

	assign issue          = (state_q == ST_PROBE) && (issued_q != CNT_W'(CAPACITY));
	assign slot_match     = (cmd_q == lpht_pkg::CMD_PUT) ? !rd_used
	                                                     : (rd_used && (rd_key == key_q));
	assign probe_hit      = (state_q == ST_PROBE) && rd_vld_s1 && slot_match;
	assign probe_miss_end = (state_q == ST_PROBE) && rd_vld_s1 && !slot_match && rd_last_s1;
	assign put_hit        = probe_hit && (cmd_q == lpht_pkg::CMD_PUT);
	assign mem_sweep      = (state_q == ST_INIT) || (state_q == ST_CLEAR);
	assign out_load       = (state_q == ST_RESULT) && (!out_valid_q || out_ch.ready);

	lpht_hash #(
		.CAPACITY  (CAPACITY),
		.KEY_BYTES (KEY_BYTES)
	) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (in_ch.key[KEY_BITS-1:0]),
		.done   (hash_done),
		.home   (hash_home)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = addr_q;
		mem_wdata = '0;
		priority if (mem_sweep) begin
			mem_we = 1'b1;
		end else if (put_hit) begin
			mem_we    = 1'b1;
			mem_waddr = rd_addr_s1;
			mem_wdata = {1'b1, key_q, val_q};
		end else if (probe_hit && (cmd_q == lpht_pkg::CMD_REMOVE)) begin
			mem_we    = 1'b1;
			mem_waddr = rd_addr_s1;
			mem_wdata = {1'b0, rd_key, rd_val};
		end
	end

	lpht_mem #(
		.DEPTH (CAPACITY),
		.WIDTH (MW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (addr_q),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_INIT;
			addr_q       <= '0;
			cnt_q        <= '0;
			issued_q     <= '0;
			cmd_q        <= lpht_pkg::CMD_PUT;
			key_q        <= '0;
			val_q        <= '0;
			res_status_q <= lpht_pkg::STATUS_OK;
			res_value_q  <= '0;
			rd_vld_s1    <= 1'b0;
			rd_last_s1   <= 1'b0;
			rd_addr_s1   <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					addr_q <= addr_next;
					if (addr_q == ADDR_W'(CAPACITY - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_accept) begin
						cmd_q <= in_ch.command;
						key_q <= in_ch.key[KEY_BITS-1:0];
						val_q <= in_val_ext[VALUE_BITS-1:0];
						if (in_ch.command == lpht_pkg::CMD_CLEAR) begin
							addr_q  <= '0;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_HASH;
						end
					end
				end
				ST_HASH: begin
					if (hash_done) begin
						if ((cmd_q == lpht_pkg::CMD_PUT) && (cnt_q == CNT_W'(CAPACITY))) begin
							res_status_q <= lpht_pkg::STATUS_FULL;
							res_value_q  <= '0;
							state_q      <= ST_RESULT;
						end else begin
							addr_q    <= hash_home;
							issued_q  <= '0;
							rd_vld_s1 <= 1'b0;
							state_q   <= ST_PROBE;
						end
					end
				end
				ST_PROBE: begin
					// read of the next slot overlaps the check of the one just read
					rd_vld_s1 <= issue && !probe_hit && !probe_miss_end;
					if (issue) begin
						rd_addr_s1 <= addr_q;
						rd_last_s1 <= (issued_q == CNT_W'(CAPACITY - 1));
						addr_q     <= addr_next;
						issued_q   <= issued_q + 1'b1;
					end
					if (probe_hit) begin
						res_status_q <= lpht_pkg::STATUS_OK;
						state_q      <= ST_RESULT;
						if (cmd_q == lpht_pkg::CMD_PUT) begin
							res_value_q <= '0;
							cnt_q       <= cnt_q + 1'b1;
						end else begin
							res_value_q <= rd_val_ext[lpht_pkg::VALUE_W-1:0];
							if (cmd_q == lpht_pkg::CMD_REMOVE) begin
								cnt_q <= cnt_q - 1'b1;
							end
						end
					end else if (probe_miss_end) begin
						res_status_q <= lpht_pkg::STATUS_NOT_FOUND;
						res_value_q  <= '0;
						state_q      <= ST_RESULT;
					end
				end
				ST_CLEAR: begin
					addr_q <= addr_next;
					if (addr_q == ADDR_W'(CAPACITY - 1)) begin
						cnt_q        <= '0;
						res_status_q <= lpht_pkg::STATUS_OK;
						res_value_q  <= '0;
						state_q      <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			out_status_q <= lpht_pkg::STATUS_OK;
			out_value_q  <= '0;
		end else if (out_load) begin
			out_valid_q  <= 1'b1;
			out_status_q <= res_status_q;
			out_value_q  <= res_value_q;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.status    = out_status_q;
	assign out_ch.value_out = out_value_q;

	`LPHT_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(CAPACITY), "entry count above capacity")
	`LPHT_ASSERT_IMPL(a_put_room, put_hit, cnt_q < CNT_W'(CAPACITY), "put into a full table")
	`LPHT_ASSERT_IMPL(a_we_state, mem_we, mem_sweep || (state_q == ST_PROBE), "stray slot write")
	`LPHT_ASSERT_IMPL(a_miss_all, probe_miss_end, issued_q == CNT_W'(CAPACITY), "early miss")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

	localparam int TABLE_SLOTS  = 16;
	localparam int KEY_BYTES    = 8;
	localparam int IDLE_PCT     = 11;
	localparam int STALL_LIMIT  = 4000;
	localparam int SETTLE_TICKS = 40;

	typedef struct packed {
		lpht_pkg::cmd_t   command;
		lpht_pkg::key_t   key;
		lpht_pkg::value_t value;
		logic             steady;
	} table_req_t;

	typedef struct packed {
		lpht_pkg::status_t status;
		lpht_pkg::value_t  value_out;
	} table_reply_t;

	logic clk;
	logic arst_n;

	lpht_in_if  in_ch ();
	lpht_out_if out_ch ();

	linear_probe_hash_table #(
		.CAPACITY   (TABLE_SLOTS),
		.KEY_BYTES  (KEY_BYTES),
		.VALUE_BITS (lpht_pkg::VALUE_W)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	table_req_t   pending_reqs[$];
	table_reply_t expected_replies[$];
	table_req_t   next_req;
	logic         steady;
	int unsigned  reqs_queued;
	int unsigned  reqs_taken;
	int unsigned  error_count;
	int unsigned  stall_cycles;

	// shadow copy of the slot memory
	bit               shadow_used[TABLE_SLOTS];
	lpht_pkg::key_t   shadow_key[TABLE_SLOTS];
	lpht_pkg::value_t shadow_value[TABLE_SLOTS];
	int unsigned      shadow_count;

	function automatic int unsigned home_of(lpht_pkg::key_t key);
		int unsigned sum;
		int unsigned b;
		sum = 0;
		for (b = 0; b < KEY_BYTES; b++)
			sum += key[8*b +: 8];
		return sum % TABLE_SLOTS;
	endfunction

	function automatic table_reply_t apply_command(lpht_pkg::cmd_t command,
			lpht_pkg::key_t key, lpht_pkg::value_t value);
		table_reply_t reply;
		int unsigned  home;
		int unsigned  slot;
		int unsigned  n;
		logic         done;
		reply.status    = lpht_pkg::STATUS_OK;
		reply.value_out = '0;
		home = home_of(key);
		done = 1'b0;
		case (command)
			lpht_pkg::CMD_PUT: begin
				if (shadow_count >= TABLE_SLOTS) begin
					reply.status = lpht_pkg::STATUS_FULL;
				end else begin
					for (n = 0; n < TABLE_SLOTS; n++) begin
						slot = (home + n) % TABLE_SLOTS;
						if (!done && !shadow_used[slot]) begin
							shadow_used[slot]  = 1'b1;
							shadow_key[slot]   = key;
							shadow_value[slot] = value;
							shadow_count++;
							done = 1'b1;
						end
					end
				end
			end
			lpht_pkg::CMD_GET, lpht_pkg::CMD_REMOVE: begin
				reply.status = lpht_pkg::STATUS_NOT_FOUND;
				for (n = 0; n < TABLE_SLOTS; n++) begin
					slot = (home + n) % TABLE_SLOTS;
					if (!done && shadow_used[slot] && shadow_key[slot] == key) begin
						reply.status    = lpht_pkg::STATUS_OK;
						reply.value_out = shadow_value[slot];
						if (command == lpht_pkg::CMD_REMOVE) begin
							shadow_used[slot] = 1'b0;
							if (shadow_count > 0)
								shadow_count--;
						end
						done = 1'b1;
					end
				end
			end
			default: begin
				for (n = 0; n < TABLE_SLOTS; n++)
					shadow_used[n] = 1'b0;
				shadow_count = 0;
			end
		endcase
		return reply;
	endfunction

	function automatic lpht_pkg::key_t rand_key();
		lpht_pkg::key_t key;
		case ($urandom_range(0, 3))
			0: key = {$urandom, $urandom};
			1: key = lpht_pkg::key_t'($urandom_range(0, 255)) << (8 * $urandom_range(0, 7));
			2: key = $urandom_range(0, 1) ? '1 : '0;
			default: key = lpht_pkg::key_t'($urandom_range(0, 65535));
		endcase
		return key;
	endfunction

	function automatic lpht_pkg::value_t rand_value();
		lpht_pkg::value_t value;
		case ($urandom_range(0, 7))
			0: value = '0;
			1: value = '1;
			default: value = $urandom;
		endcase
		return value;
	endfunction

	task automatic send(input lpht_pkg::cmd_t command, input lpht_pkg::key_t key,
			input lpht_pkg::value_t value, input logic hold_steady);
		table_req_t req;
		req.command = command;
		req.key     = key;
		req.value   = value;
		req.steady  = hold_steady;
		pending_reqs.push_back(req);
		reqs_queued++;
	endtask

	task automatic wait_for_drain();
		while (reqs_taken != reqs_queued || expected_replies.size() != 0)
			@(posedge clk);
	endtask

	// episodes over a small pool of keys so that gets and removes mostly hit
	task automatic queue_random(input int unsigned count, input int unsigned steady_lo,
			input int unsigned steady_hi);
		lpht_pkg::key_t pool[$];
		lpht_pkg::key_t key;
		int unsigned    made;
		int unsigned    pool_size;
		int unsigned    ops;
		int unsigned    sel;
		int unsigned    i;
		int unsigned    rot;
		logic           hold;
		made = 0;
		while (made < count) begin
			pool.delete();
			pool_size = $urandom_range(2, 14);
			for (i = 0; i < pool_size; i++) begin
				if (i > 0 && $urandom_range(0, 3) == 0) begin
					// byte rotation keeps the byte sum, so the home slot collides
					key = pool[$urandom_range(0, i - 1)];
					rot = $urandom_range(1, 7);
					key = (key << (8 * rot)) | (key >> (64 - 8 * rot));
				end else begin
					key = rand_key();
				end
				pool.push_back(key);
			end
			ops = $urandom_range(20, 60);
			while (ops != 0 && made < count) begin
				sel  = $urandom_range(0, 99);
				key  = pool[$urandom_range(0, pool.size() - 1)];
				hold = (made >= steady_lo && made < steady_hi);
				if (sel < 42)
					send(lpht_pkg::CMD_PUT, key, rand_value(), hold);
				else if (sel < 66)
					send(lpht_pkg::CMD_GET, key, rand_value(), hold);
				else if (sel < 88)
					send(lpht_pkg::CMD_REMOVE, key, rand_value(), hold);
				else if (sel < 94)
					send($urandom_range(0, 1) ? lpht_pkg::CMD_GET : lpht_pkg::CMD_REMOVE,
						rand_key(), rand_value(), hold);
				else if (sel < 98)
					send(lpht_pkg::CMD_PUT, rand_key(), rand_value(), hold);
				else
					send(lpht_pkg::CMD_CLEAR, {$urandom, $urandom}, $urandom, hold);
				made++;
				ops--;
			end
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.command <= lpht_pkg::CMD_CLEAR;
			in_ch.key     <= '0;
			in_ch.value   <= '0;
			steady        <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_replies.push_back(apply_command(in_ch.command, in_ch.key,
					in_ch.value));
				reqs_taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pending_reqs.size() != 0 &&
						(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
					next_req = pending_reqs.pop_front();
					in_ch.valid   <= 1'b1;
					in_ch.command <= next_req.command;
					in_ch.key     <= next_req.key;
					in_ch.value   <= next_req.value;
					steady        <= next_req.steady;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else
			out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_replies.size() == 0) begin
				$error("unexpected transaction: status %0d, value_out 0x%08h",
					out_ch.status, out_ch.value_out);
				error_count++;
			end else begin
				if (out_ch.status !== expected_replies[0].status) begin
					$error("status mismatch: expected %0d, actual %0d",
						expected_replies[0].status, out_ch.status);
					error_count++;
				end
				if (out_ch.value_out !== expected_replies[0].value_out) begin
					$error("value_out mismatch: expected 0x%08h, actual 0x%08h",
						expected_replies[0].value_out, out_ch.value_out);
					error_count++;
				end
				void'(expected_replies.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && !(in_ch.valid && in_ch.ready) && !(out_ch.valid && out_ch.ready)) begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$error("timeout: no transaction for %0d cycles", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end
		end else begin
			stall_cycles = 0;
		end
	end

	initial begin
		int unsigned n;
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, duplicates, colliding keys with interior zero bytes, full table
		send(lpht_pkg::CMD_CLEAR, '1, '1, 1'b0);
		send(lpht_pkg::CMD_PUT, '0, '0, 1'b0);
		send(lpht_pkg::CMD_PUT, '1, '1, 1'b0);
		send(lpht_pkg::CMD_GET, '0, '1, 1'b0);
		send(lpht_pkg::CMD_GET, 64'h0000_0000_0000_0010, '0, 1'b0);
		send(lpht_pkg::CMD_PUT, '0, 32'h1234_5678, 1'b0);
		send(lpht_pkg::CMD_GET, '0, '0, 1'b0);
		send(lpht_pkg::CMD_REMOVE, '0, '0, 1'b0);
		send(lpht_pkg::CMD_GET, '0, '0, 1'b0);
		send(lpht_pkg::CMD_PUT, 64'h0000_00ff_0000_0001, 32'h0000_00c1, 1'b0);
		send(lpht_pkg::CMD_PUT, 64'h0100_0000_0000_00ff, 32'h8000_0000, 1'b0);
		send(lpht_pkg::CMD_GET, 64'h0000_00ff_0000_0001, '0, 1'b0);
		send(lpht_pkg::CMD_GET, 64'h0100_0000_0000_00ff, '0, 1'b0);
		send(lpht_pkg::CMD_REMOVE, 64'h0000_0000_0000_0010, '0, 1'b0);
		for (n = 0; n < 12; n++)
			send(lpht_pkg::CMD_PUT, {$urandom, $urandom}, $urandom, 1'b0);
		send(lpht_pkg::CMD_PUT, '1, 32'hdead_beef, 1'b0);
		send(lpht_pkg::CMD_CLEAR, '0, '0, 1'b0);
		send(lpht_pkg::CMD_GET, '1, '0, 1'b0);
		wait_for_drain();

		queue_random(550, 200, 330);
		// hold off the sender until the table has answered everything
		wait_for_drain();
		queue_random(550, 0, 0);
		wait_for_drain();
		repeat (SETTLE_TICKS) @(posedge clk);

		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lpht_pkg.sv
rtl/lpht_if.sv
rtl/lpht_hash.sv
rtl/lpht_mem.sv
rtl/linear_probe_hash_table.sv
verif/testbench.sv
